>>> src/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg: shared types and constants for the Merkle root hasher
// Round constants, initial hash value, message block helpers, state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mrs_pkg;

  localparam int LEVELS = 20;
  localparam int IDX_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LVL_W  = $clog2(LEVELS + 1);

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Final block of a 128-byte message: pad marker, zeros, bit length 1024.
  localparam logic [511:0] PAD_BLOCK = {8'h80, 440'd0, 64'd1024};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAF,
    ST_SCAN,
    ST_READ,
    ST_MERGE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic         start;
    logic [511:0] blk;
    logic [255:0] h;
  } sha_req_t;

  typedef struct packed {
    logic         we;
    logic [IDX_W-1:0] waddr;
    logic [255:0] wdata;
    logic         re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    logic [31:0] r;
    r = (x >> n) | (x << (32 - n));
    return r;
  endfunction

  // One-byte message in a single block: byte, pad marker, bit length 8.
  function automatic logic [511:0] leaf_block(input logic [7:0] b);
    return {b, 8'h80, 432'd0, 64'd8};
  endfunction

  // Lowercase ASCII hex of a digest, most significant nibble first.
  function automatic logic [511:0] hex_block(input logic [255:0] d);
    logic [511:0] r;
    logic [3:0]   nib;
    for (int i = 0; i < 64; i++) begin
      nib = d[255 - 4*i -: 4];
      r[511 - 8*i -: 8] = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/mrs_if.sv
// ----------------------------------------------------------------------------
// mrs_if: leaf and root channels
// Valid/ready channels; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] leaf_byte;
  logic       is_last;
  modport source (output valid, leaf_byte, is_last, input ready);
  modport sink   (input valid, leaf_byte, is_last, output ready);
endinterface

interface mrs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] root_word0;
  logic [63:0] root_word1;
  logic [63:0] root_word2;
  logic [63:0] root_word3;
  logic        too_many_leaves;
  modport source (output valid, root_word0, root_word1, root_word2, root_word3,
                  too_many_leaves, input ready);
  modport sink   (input valid, root_word0, root_word1, root_word2, root_word3,
                  too_many_leaves, output ready);
endinterface

`default_nettype wire

>>> src/mrs_sha_core.sv
// ----------------------------------------------------------------------------
// mrs_sha_core: SHA-256 compression, one round per cycle
// Takes a block and a chaining value, returns the updated value after 64 rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_sha_core import mrs_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire sha_req_t     req_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [255:0]      digest_o
);

  logic [31:0]  v_q [8];
  logic [31:0]  w_q [16];
  logic [255:0] hs_q;
  logic [5:0]   rnd_q;
  logic         busy_q;
  logic         fin_q;

  logic [31:0] big0, big1, ch, maj, t1, t2, s0, s1, w_new;

  always_comb begin
    big1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1    = v_q[7] + big1 + ch + ROUND_K[rnd_q] + w_q[0];
    big0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2    = big0 + maj;
    s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
    end else begin
      fin_q <= busy_q && (rnd_q == 6'd63);
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      hs_q <= req_i.h;
      for (int i = 0; i < 8; i++) v_q[i] <= req_i.h[255 - 32*i -: 32];
      for (int i = 0; i < 16; i++) w_q[i] <= req_i.blk[511 - 32*i -: 32];
    end else if (busy_q) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) digest_o[255 - 32*i -: 32] = hs_q[255 - 32*i -: 32] + v_q[i];
  end

  assign busy_o = busy_q;
  assign done_o = fin_q;

endmodule

`default_nettype wire

>>> src/mrs_digest_ram.sv
// ----------------------------------------------------------------------------
// mrs_digest_ram: pending digest store, one row per tree level
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_digest_ram import mrs_pkg::*; (
  input  wire logic     clk_i,
  input  wire ram_req_t req_i,
  output logic [255:0]  rdata_o
);

  logic [255:0] mem_q [LEVELS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_o <= mem_q[req_i.raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/merkle_root_sha256.sv
// ----------------------------------------------------------------------------
// merkle_root_sha256: streaming Merkle root over one-byte leaves
// Sequencer around one SHA-256 round engine and the per-level digest store.
// ----------------------------------------------------------------------------
//   channel  dir  beat contents
//   in_i     in   leaf_byte, is_last
//   out_o    out  root_word0..3, too_many_leaves (one beat after a last leaf)
//
// A leaf is hashed on its own, then merged with each occupied level it meets
// (a store read and three compressions); the last leaf walks all LEVELS levels,
// merging with each occupied one and passing each empty one. Reset clears the
// occupancy bits and the overflow flag; the store needs no clearing. A stalled
// root beat holds in its register; a new leaf is accepted meanwhile, and the
// next root waits until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module merkle_root_sha256 import mrs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mrs_in_if.sink    in_i,
  mrs_out_if.source out_o
);

  state_e           state_q, state_d;
  logic [LEVELS-1:0] occ_q;
  logic             ovf_q;
  logic [LVL_W-1:0] lvl_q;
  logic [1:0]       blk_q;
  logic             last_q;
  logic [255:0]     cur_q;
  logic             out_valid_q;
  logic [255:0]     out_root_q;
  logic             out_ovf_q;

  sha_req_t     sha_req;
  logic         sha_busy, sha_done;
  logic [255:0] sha_digest;
  ram_req_t     ram_req;
  logic [255:0] ram_rdata;

  logic [IDX_W-1:0] idx;
  logic             at_top;
  logic             out_free;

  mrs_sha_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (sha_req),
    .busy_o   (sha_busy),
    .done_o   (sha_done),
    .digest_o (sha_digest)
  );

  mrs_digest_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign idx      = lvl_q[IDX_W-1:0];
  assign at_top   = (lvl_q == LVL_W'(LEVELS));
  assign out_free = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_i.valid) state_d = ST_LEAF;
      ST_LEAF:  if (sha_done) state_d = ST_SCAN;
      ST_SCAN: begin
        priority if (at_top) state_d = last_q ? ST_OUT : ST_IDLE;
        else if (occ_q[idx]) state_d = ST_READ;
        else if (!last_q) state_d = ST_IDLE;
        else state_d = ST_SCAN;
      end
      ST_READ:  state_d = ST_MERGE;
      ST_MERGE: if (sha_done && blk_q == 2'd2) state_d = ST_SCAN;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs to the hash engine and store
  always_comb begin
    sha_req = '{start: 1'b0, blk: leaf_block(in_i.leaf_byte), h: INIT_H};
    ram_req = '{we: 1'b0, waddr: idx, wdata: cur_q, re: 1'b0, raddr: idx};
    unique case (state_q)
      ST_IDLE:  sha_req.start = in_i.valid;
      ST_SCAN: begin
        if (!at_top) begin
          ram_req.re = occ_q[idx];
          ram_req.we = !occ_q[idx] && !last_q;
        end
      end
      ST_READ: begin
        sha_req.start = 1'b1;
        sha_req.blk   = hex_block(ram_rdata);
      end
      ST_MERGE: begin
        sha_req.start = sha_done && (blk_q != 2'd2);
        sha_req.h     = sha_digest;
        sha_req.blk   = (blk_q == 2'd0) ? hex_block(cur_q) : PAD_BLOCK;
      end
      default: ;
    endcase
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      ovf_q       <= 1'b0;
      lvl_q       <= '0;
      blk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_LEAF: lvl_q <= '0;
        ST_SCAN: begin
          if (at_top) begin
            if (!last_q) ovf_q <= 1'b1;   // carry ran off the top: drop it
          end else if (!occ_q[idx]) begin
            if (last_q) lvl_q <= lvl_q + 1'b1;
            else occ_q[idx] <= 1'b1;
          end
        end
        ST_READ: blk_q <= '0;
        ST_MERGE: begin
          if (sha_done) begin
            blk_q <= blk_q + 2'd1;
            if (blk_q == 2'd2) begin
              occ_q[idx] <= 1'b0;
              lvl_q      <= lvl_q + 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            occ_q       <= '0;
            ovf_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) last_q <= in_i.is_last;
    if ((state_q == ST_LEAF || state_q == ST_MERGE) && sha_done) cur_q <= sha_digest;
    if (state_q == ST_OUT && out_free) begin
      out_root_q <= cur_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.root_word0      = out_root_q[255:192];
  assign out_o.root_word1      = out_root_q[191:128];
  assign out_o.root_word2      = out_root_q[127:64];
  assign out_o.root_word3      = out_root_q[63:0];
  assign out_o.too_many_leaves = out_ovf_q;

  a_idle_engine_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !sha_busy) else $error("hash engine busy while idle");

  a_ram_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re)) else $error("store read and write together");

  a_root_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT)) else $error("root beat out of sequence");

  a_merge_start_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sha_req.start && state_q != ST_IDLE |-> !sha_busy)
    else $error("hash started while running");

endmodule

`default_nettype wire

>>> dv/tb_merkle_root_sha256.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_merkle_root_sha256: self-checking bench for the streaming Merkle root
// Drives one-byte leaves in trees of varied size with random gaps on both
// channels. A SHA-256 tree model kept in the bench predicts each root beat,
// and every root beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_merkle_root_sha256;

  localparam int TREE_LEVELS = 20;
  localparam int HOLD_CYCLES = 3000;
  localparam int IDLE_LIMIT  = 40000;
  localparam int TAIL_CYCLES = 5000;
  localparam int RAND_LEAVES = 1000;

  typedef struct {
    logic [63:0] word [4];
    logic        overflow;
  } root_beat_t;

  typedef struct {
    logic [7:0]   leaf;
    logic         last;
    bit           known;
    logic [255:0] digest;
  } leaf_row_t;

  localparam logic [31:0] K256 [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] H256_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mrs_in_if  leaf_ch ();
  mrs_out_if root_ch ();

  merkle_root_sha256 u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (leaf_ch),
    .out_o  (root_ch)
  );

  always #5 clk_i = ~clk_i;

  // Tree model state
  logic [255:0] level_digest [TREE_LEVELS];
  logic [TREE_LEVELS-1:0] level_full;
  logic         tree_overflow;

  root_beat_t root_expect_q [$];
  int  mismatches;
  int  idle_cycles;
  bit  hold_req;
  bit  rx_quiet;
  int  rx_hold;
  int  rx_gap;
  bit  tx_quiet;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] sha_compress(input logic [255:0] hv,
                                                input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    logic [255:0] r;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hv[255 - 32*i -: 32];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + K256[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) r[255 - 32*i -: 32] = hv[255 - 32*i -: 32] + v[i];
    return r;
  endfunction

  function automatic logic [511:0] ascii_hex(input logic [255:0] d);
    logic [511:0] r;
    logic [3:0]   nib;
    for (int i = 0; i < 64; i++) begin
      nib = d[255 - 4*i -: 4];
      r[511 - 8*i -: 8] = (nib < 4'd10) ? 8'h30 + nib : 8'h57 + nib;
    end
    return r;
  endfunction

  function automatic logic [255:0] leaf_digest(input logic [7:0] b);
    return sha_compress(H256_INIT, {b, 8'h80, 432'd0, 64'd8});
  endfunction

  // Parent = H(hex(left) || hex(right)): two text blocks and a padding block.
  function automatic logic [255:0] node_digest(input logic [255:0] l,
                                               input logic [255:0] r);
    logic [255:0] h;
    h = sha_compress(H256_INIT, ascii_hex(l));
    h = sha_compress(h, ascii_hex(r));
    return sha_compress(h, {8'h80, 440'd0, 64'd1024});
  endfunction

  // Advance the tree by one leaf; returns 1 with the root on a last leaf.
  function automatic bit tree_step(input logic [7:0] b, input logic last,
                                   output root_beat_t beat);
    logic [255:0] cur;
    int lvl;
    cur = leaf_digest(b);
    if (!last) begin
      lvl = 0;
      while (lvl < TREE_LEVELS && level_full[lvl]) begin
        cur = node_digest(level_digest[lvl], cur);
        level_full[lvl] = 1'b0;
        lvl++;
      end
      if (lvl < TREE_LEVELS) begin
        level_digest[lvl] = cur;
        level_full[lvl] = 1'b1;
      end else begin
        tree_overflow = 1'b1;
      end
      return 1'b0;
    end
    for (int i = 0; i < TREE_LEVELS; i++)
      if (level_full[i]) cur = node_digest(level_digest[i], cur);
    for (int i = 0; i < 4; i++) beat.word[i] = cur[255 - 64*i -: 64];
    beat.overflow = tree_overflow;
    level_full = '0;
    tree_overflow = 1'b0;
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // Offer one leaf beat, hold it until accepted, then predict.
  task automatic send_leaf(input logic [7:0] b, input logic last,
                           input bit known, input logic [255:0] kdig);
    int gap;
    root_beat_t beat;
    gap = tx_quiet ? 0 : gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      leaf_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    leaf_ch.valid     = 1'b1;
    leaf_ch.leaf_byte = b;
    leaf_ch.is_last   = last;
    do @(posedge clk_i); while (!leaf_ch.ready);
    if (tree_step(b, last, beat)) begin
      if (known)
        for (int i = 0; i < 4; i++) beat.word[i] = kdig[255 - 64*i -: 64];
      root_expect_q.push_back(beat);
    end
  endtask

  function automatic logic [7:0] rand_leaf();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  task automatic send_tree(input int n);
    for (int i = 0; i < n; i++) send_leaf(rand_leaf(), i == n - 1, 1'b0, '0);
  endtask

  // Receiver: long hold-off on request, otherwise random gaps.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      rx_hold = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      root_ch.ready = 1'b0;
      rx_hold--;
    end else if (rx_gap > 0) begin
      root_ch.ready = 1'b0;
      rx_gap--;
    end else begin
      root_ch.ready = 1'b1;
    end
  end

  // Root beat checker
  always @(posedge clk_i) begin
    root_beat_t exp_beat;
    if (rst_ni && root_ch.valid && root_ch.ready) begin
      rx_gap = rx_quiet ? 0 : gap_len();
      if (root_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: root beat with nothing expected: %h %h %h %h",
                   root_ch.root_word0, root_ch.root_word1,
                   root_ch.root_word2, root_ch.root_word3);
      end else begin
        exp_beat = root_expect_q.pop_front();
        if (root_ch.root_word0 !== exp_beat.word[0] ||
            root_ch.root_word1 !== exp_beat.word[1] ||
            root_ch.root_word2 !== exp_beat.word[2] ||
            root_ch.root_word3 !== exp_beat.word[3] ||
            root_ch.too_many_leaves !== exp_beat.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: root exp %h%h%h%h/%b got %h%h%h%h/%b",
                     exp_beat.word[0], exp_beat.word[1], exp_beat.word[2],
                     exp_beat.word[3], exp_beat.overflow,
                     root_ch.root_word0, root_ch.root_word1,
                     root_ch.root_word2, root_ch.root_word3,
                     root_ch.too_many_leaves);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((leaf_ch.valid && leaf_ch.ready) || (root_ch.valid && root_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  leaf_row_t directed [21];

  initial begin
    int sent;
    int r;
    int n;
    bit pressed;
    directed = '{
      '{8'h61, 1'b1, 1'b1,
        256'hca978112ca1bbdcafac231b39a23dc4da786eff8147c4e72b9807785afee48bb},
      '{8'h00, 1'b1, 1'b0, '0}, '{8'hff, 1'b1, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'hff, 1'b1, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0}, '{8'h7f, 1'b1, 1'b0, '0},
      '{8'haa, 1'b0, 1'b0, '0}, '{8'h55, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'hff, 1'b0, 1'b0, '0}, '{8'hf0, 1'b1, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0}, '{8'h02, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b0, '0}, '{8'h04, 1'b0, 1'b0, '0}, '{8'h05, 1'b0, 1'b0, '0},
      '{8'h06, 1'b0, 1'b0, '0}, '{8'h07, 1'b1, 1'b0, '0}
    };
    leaf_ch.valid = 1'b0;
    leaf_ch.leaf_byte = '0;
    leaf_ch.is_last = 1'b0;
    root_ch.ready = 1'b0;
    level_full = '0;
    tree_overflow = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    rx_hold = 0;
    rx_gap = 0;
    rx_quiet = 1'b0;
    tx_quiet = 1'b0;
    pressed = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i])
      send_leaf(directed[i].leaf, directed[i].last, directed[i].known,
                directed[i].digest);

    sent = 0;
    while (sent < RAND_LEAVES) begin
      // Stall the root side while short trees pile up behind it.
      if (!pressed && sent >= 300) begin
        pressed = 1'b1;
        hold_req = 1'b1;
        tx_quiet = 1'b1;
        for (int t = 0; t < 10; t++) begin
          n = $urandom_range(1, 2);
          send_tree(n);
          sent += n;
        end
        tx_quiet = 1'b0;
        // Drain everything before going on.
        @(negedge clk_i);
        leaf_ch.valid = 1'b0;
        while (root_expect_q.size() != 0) @(posedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 8);
      else if (r < 96) n = $urandom_range(9, 40);
      else n = $urandom_range(100, 260);
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      send_tree(n);
      sent += n;
    end

    @(negedge clk_i);
    leaf_ch.valid = 1'b0;
    while (root_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && root_expect_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/mrs_pkg.sv
src/mrs_if.sv
src/mrs_sha_core.sv
src/mrs_digest_ram.sv
src/merkle_root_sha256.sv
dv/tb_merkle_root_sha256.sv
